// File: design/graph_k_core_peeler_top_defines.svh
// assertion helpers used by the checker file
`ifndef GRAPH_K_CORE_PEELER_TOP_DEFINES_SVH
`define GRAPH_K_CORE_PEELER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define KCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/kcp_pkg.sv
`default_nettype none
package kcp_pkg;

  localparam int KCP_MAX_VERTICES = 64;
  localparam int FIELD_W = 7;
  localparam int OP_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_RUN      = 2'd1,
    OP_CLEAR    = 2'd2
  } op_t;

  localparam logic REG_MIN_DEGREE   = 1'b0;
  localparam logic REG_VERTEX_COUNT = 1'b1;

  localparam logic [FIELD_W-1:0] MIN_DEGREE_RESET   = 7'd1;
  localparam logic [FIELD_W-1:0] VERTEX_COUNT_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_RD_A,
    ST_EDGE_WR_A,
    ST_EDGE_RD_B,
    ST_EDGE_WR_B,
    ST_PEEL_RD,
    ST_PEEL_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } mem_ctl_t;

endpackage
`default_nettype wire

// File: design/graph_k_core_peeler_top.sv
// channel   direction  handshake                   payload
// input     in         in_valid / in_stall         operation, vertex_a, vertex_b
// output    out        out_valid / out_stall       survivor_count
// config    in         write_enable (no wait)      write_index, write_data
//
// add edge: accept, then a read and a write of each of the two rows; clear, bad edge and
// unused code: accept only. run: each pass reads and evaluates every live vertex and skips
// removed ones; passes repeat until one removes nothing (at most vertex_count + 1), then
// the survivors are counted.
// reset clears control state and the row valid bits; no clearing pass.
// in_stall high while an item is in work; a run holds its last state while out_stall blocks
`default_nettype none
module graph_k_core_peeler_top #(
  parameter int MAX_VERTICES = kcp_pkg::KCP_MAX_VERTICES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [kcp_pkg::OP_W-1:0]      operation,
  input  wire logic [kcp_pkg::FIELD_W-1:0]   vertex_a,
  input  wire logic [kcp_pkg::FIELD_W-1:0]   vertex_b,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [kcp_pkg::FIELD_W-1:0]   survivor_count,
  input  wire logic                          write_enable,
  input  wire logic                          write_index,
  input  wire logic [kcp_pkg::FIELD_W-1:0]   write_data
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int FW = kcp_pkg::FIELD_W;

  logic [FW-1:0] min_degree;
  logic [FW-1:0] vertex_count;
  logic [CW-1:0] active;

  kcp_pkg::mem_ctl_t       mem_ctl;
  logic [VW-1:0]           rd_addr;
  logic [VW-1:0]           wr_addr;
  logic [MAX_VERTICES-1:0] wr_data;
  logic [MAX_VERTICES-1:0] rd_data;
  logic [MAX_VERTICES-1:0] cnt_row;
  logic [MAX_VERTICES-1:0] cnt_mask;
  logic [CW-1:0]           cnt;
  logic                    cnt_below;
  logic                    out_free;
  logic                    res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_degree   <= kcp_pkg::MIN_DEGREE_RESET;
      vertex_count <= kcp_pkg::VERTEX_COUNT_RESET;
    end else if (write_enable) begin
      case (write_index)
        kcp_pkg::REG_MIN_DEGREE:   min_degree   <= write_data;
        kcp_pkg::REG_VERTEX_COUNT: vertex_count <= write_data;
        default:                   min_degree   <= min_degree;
      endcase
    end
  end

  // vertices in use, saturated at the matrix size
  assign active = (vertex_count > FW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vertex_count);

  assign out_free = !out_valid || !out_stall;

  kcp_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .vertex_a  (vertex_a),
    .vertex_b  (vertex_b),
    .active    (active),
    .mem_ctl   (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data   (rd_data),
    .cnt_row   (cnt_row),
    .cnt_mask  (cnt_mask),
    .cnt_below (cnt_below),
    .out_free  (out_free),
    .res_load  (res_load)
  );

  kcp_adj_mem #(
    .ROWS (MAX_VERTICES),
    .WIDTH(MAX_VERTICES)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mem_ctl),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  kcp_count #(
    .WIDTH(MAX_VERTICES)
  ) u_count (
    .row  (cnt_row),
    .mask (cnt_mask),
    .need (min_degree),
    .count(cnt),
    .below(cnt_below)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      survivor_count <= FW'(cnt);
    end
  end

endmodule
`default_nettype wire

// File: design/kcp_adj_mem.sv
`default_nettype none
module kcp_adj_mem #(
  parameter int ROWS  = kcp_pkg::KCP_MAX_VERTICES,
  parameter int WIDTH = kcp_pkg::KCP_MAX_VERTICES
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire kcp_pkg::mem_ctl_t        ctl,
  input  wire logic [$clog2(ROWS)-1:0]  rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic [$clog2(ROWS)-1:0]  wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_valid;
  logic [WIDTH-1:0] rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  // a row never written since reset or clear reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (ctl.clr) begin
        row_valid <= '0;
      end else if (ctl.wr) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd) begin
        rd_vld <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule
`default_nettype wire

// File: design/kcp_count.sv
`default_nettype none
module kcp_count #(
  parameter int WIDTH = kcp_pkg::KCP_MAX_VERTICES
) (
  input  wire logic [WIDTH-1:0]              row,
  input  wire logic [WIDTH-1:0]              mask,
  input  wire logic [kcp_pkg::FIELD_W-1:0]   need,
  output logic      [$clog2(WIDTH+1)-1:0]    count,
  output logic                               below
);

  localparam int CW = $clog2(WIDTH + 1);
  localparam int NB = (WIDTH + 7) / 8;

  logic [NB*8-1:0] padded;
  logic [3:0]      byte_cnt [NB];

  assign padded = (NB*8)'(row & mask);

  // per-byte counts first, then a short sum of the bytes
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(padded[b*8+k]);
      end
    end
  end

  always_comb begin
    count = '0;
    for (int b = 0; b < NB; b++) begin
      count = count + CW'(byte_cnt[b]);
    end
  end

  assign below = (kcp_pkg::FIELD_W'(count) < need);

endmodule
`default_nettype wire

// File: design/kcp_ctrl.sv
`default_nettype none
module kcp_ctrl #(
  parameter int MAX_VERTICES = kcp_pkg::KCP_MAX_VERTICES
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [kcp_pkg::OP_W-1:0]            operation,
  input  wire logic [kcp_pkg::FIELD_W-1:0]         vertex_a,
  input  wire logic [kcp_pkg::FIELD_W-1:0]         vertex_b,
  input  wire logic [$clog2(MAX_VERTICES+1)-1:0]   active,
  output kcp_pkg::mem_ctl_t                        mem_ctl,
  output logic      [$clog2(MAX_VERTICES)-1:0]     rd_addr,
  output logic      [$clog2(MAX_VERTICES)-1:0]     wr_addr,
  output logic      [MAX_VERTICES-1:0]             wr_data,
  input  wire logic [MAX_VERTICES-1:0]             rd_data,
  output logic      [MAX_VERTICES-1:0]             cnt_row,
  output logic      [MAX_VERTICES-1:0]             cnt_mask,
  input  wire logic                                cnt_below,
  input  wire logic                                out_free,
  output logic                                     res_load
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int FW = kcp_pkg::FIELD_W;

  kcp_pkg::state_t state, state_next;

  logic [VW-1:0]           a_idx, a_idx_next;
  logic [VW-1:0]           b_idx, b_idx_next;
  logic [VW-1:0]           vidx, vidx_next;
  logic                    changed, changed_next;
  logic [MAX_VERTICES-1:0] removed, removed_next;
  logic [MAX_VERTICES-1:0] in_use;

  logic acc;
  logic edge_ok;
  logic last;

  assign acc      = in_valid && (state == kcp_pkg::ST_IDLE);
  assign in_stall = (state != kcp_pkg::ST_IDLE);
  assign edge_ok  = (vertex_a != '0) && (vertex_b != '0) &&
                    (vertex_a <= FW'(active)) && (vertex_b <= FW'(active));
  assign last     = (vidx == VW'(active - CW'(1)));

  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      in_use[j] = (CW'(j) < active);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kcp_pkg::ST_IDLE: begin
        if (acc) begin
          case (operation)
            kcp_pkg::OP_ADD_EDGE: begin
              if (edge_ok) state_next = kcp_pkg::ST_EDGE_RD_A;
            end
            kcp_pkg::OP_RUN: begin
              state_next = (active == '0) ? kcp_pkg::ST_DONE : kcp_pkg::ST_PEEL_RD;
            end
            default: state_next = kcp_pkg::ST_IDLE;
          endcase
        end
      end
      kcp_pkg::ST_EDGE_RD_A: state_next = kcp_pkg::ST_EDGE_WR_A;
      kcp_pkg::ST_EDGE_WR_A: state_next = kcp_pkg::ST_EDGE_RD_B;
      kcp_pkg::ST_EDGE_RD_B: state_next = kcp_pkg::ST_EDGE_WR_B;
      kcp_pkg::ST_EDGE_WR_B: state_next = kcp_pkg::ST_IDLE;
      kcp_pkg::ST_PEEL_RD: begin
        if (!removed[vidx]) begin
          state_next = kcp_pkg::ST_PEEL_EVAL;
        end else if (last && !changed) begin
          state_next = kcp_pkg::ST_DONE;
        end else begin
          state_next = kcp_pkg::ST_PEEL_RD;
        end
      end
      kcp_pkg::ST_PEEL_EVAL: begin
        if (last && !changed && !cnt_below) begin
          state_next = kcp_pkg::ST_DONE;
        end else begin
          state_next = kcp_pkg::ST_PEEL_RD;
        end
      end
      kcp_pkg::ST_DONE: begin
        if (out_free) state_next = kcp_pkg::ST_IDLE;
      end
      default: state_next = kcp_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    logic step;
    logic drop;
    mem_ctl      = '0;
    rd_addr      = a_idx;
    wr_addr      = a_idx;
    wr_data      = rd_data | (MAX_VERTICES'(1) << b_idx);
    cnt_row      = (state == kcp_pkg::ST_DONE) ? '1 : rd_data;
    cnt_mask     = in_use & ~removed;
    res_load     = 1'b0;
    a_idx_next   = a_idx;
    b_idx_next   = b_idx;
    vidx_next    = vidx;
    changed_next = changed;
    removed_next = removed;
    step         = 1'b0;
    drop         = 1'b0;
    case (state)
      kcp_pkg::ST_IDLE: begin
        if (acc) begin
          a_idx_next   = VW'(vertex_a - FW'(1));
          b_idx_next   = VW'(vertex_b - FW'(1));
          vidx_next    = '0;
          changed_next = 1'b0;
          if (operation == kcp_pkg::OP_CLEAR) begin
            mem_ctl.clr  = 1'b1;
            removed_next = '0;
          end
        end
      end
      kcp_pkg::ST_EDGE_RD_A: begin
        mem_ctl.rd = 1'b1;
      end
      kcp_pkg::ST_EDGE_WR_A: begin
        mem_ctl.wr = 1'b1;
      end
      kcp_pkg::ST_EDGE_RD_B: begin
        mem_ctl.rd = 1'b1;
        rd_addr    = b_idx;
      end
      kcp_pkg::ST_EDGE_WR_B: begin
        mem_ctl.wr = 1'b1;
        wr_addr    = b_idx;
        wr_data    = rd_data | (MAX_VERTICES'(1) << a_idx);
      end
      kcp_pkg::ST_PEEL_RD: begin
        rd_addr    = vidx;
        mem_ctl.rd = !removed[vidx];
        step       = removed[vidx];
      end
      kcp_pkg::ST_PEEL_EVAL: begin
        step = 1'b1;
        drop = cnt_below;
        if (cnt_below) begin
          removed_next = removed | (MAX_VERTICES'(1) << vidx);
        end
      end
      kcp_pkg::ST_DONE: begin
        res_load = out_free;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
    // move to the next vertex; wrap to a new pass at the last one
    if (step) begin
      if (last) begin
        vidx_next    = '0;
        changed_next = 1'b0;
      end else begin
        vidx_next    = vidx + VW'(1);
        changed_next = changed | drop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= kcp_pkg::ST_IDLE;
      vidx    <= '0;
      changed <= 1'b0;
      removed <= '0;
    end else begin
      state   <= state_next;
      vidx    <= vidx_next;
      changed <= changed_next;
      removed <= removed_next;
    end
  end

  always_ff @(posedge clk) begin
    a_idx <= a_idx_next;
    b_idx <= b_idx_next;
  end

endmodule
`default_nettype wire

// File: design/kcp_checker.sv
`default_nettype none
`include "graph_k_core_peeler_top_defines.svh"
module kcp_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [kcp_pkg::OP_W-1:0]      operation,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [kcp_pkg::FIELD_W-1:0]   survivor_count
);

  // a result held under stall keeps its value
  `KCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(survivor_count), "result changed while stalled")

  // an accepted run transaction always makes the block busy in the next cycle
  `KCP_ASSERT_NEXT(a_run_busy, in_valid && !in_stall && operation == kcp_pkg::OP_RUN, in_stall, "run accepted without going busy")

  // a new result only appears at the end of a run, while input is held off
  `KCP_ASSERT_NOW(a_out_from_run, $rose(out_valid), $past(in_stall), "result without a run in work")

  // the survivor count never exceeds the matrix size
  `KCP_ASSERT_NOW(a_count_range, out_valid, survivor_count <= kcp_pkg::FIELD_W'(kcp_pkg::KCP_MAX_VERTICES), "survivor count out of range")

endmodule

bind graph_k_core_peeler_top kcp_checker u_kcp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .operation     (operation),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .survivor_count(survivor_count)
);
`default_nettype wire
